FILE: rtl/core/dld_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dld_pkg
// Shared constants and control types of the decimal long divider.
// ----------------------------------------------------------------------------
package dld_pkg;

  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned QUOT_W  = 31;

  localparam logic [QUOT_W-1:0]  QUOT_MAX  = 31'h7FFF_FFFF;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
  localparam logic [DIGIT_W-1:0] RADIX     = 4'd10;

  // request types of an input item
  localparam logic REQ_DIVIDEND = 1'b0;
  localparam logic REQ_DIVISOR  = 1'b1;

  // control of the digit subtractor
  typedef struct packed {
    logic clear;
    logic step;
  } sub_ctl_t;

  // control of the quotient accumulator
  typedef struct packed {
    logic clear;
    logic step;
  } acc_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/core/dld_digit_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dld_digit_ram
// Single write, single read digit store with registered read data.
// ----------------------------------------------------------------------------
module dld_digit_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  wire logic                            clk,
  input  wire logic                            wr_en,
  input  wire logic [AW-1:0]                   wr_addr,
  input  wire logic [dld_pkg::DIGIT_W-1:0]     wr_data,
  input  wire logic [AW-1:0]                   rd_addr,
  output logic      [dld_pkg::DIGIT_W-1:0]     rd_data
);

  logic [dld_pkg::DIGIT_W-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/dld_digit_sub.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dld_digit_sub
// Serial decimal subtractor: one digit per step, least significant first,
// with the borrow held between steps.
// ----------------------------------------------------------------------------
module dld_digit_sub (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire dld_pkg::sub_ctl_t             ctl,
  input  wire logic [dld_pkg::DIGIT_W-1:0]   a_digit,
  input  wire logic [dld_pkg::DIGIT_W-1:0]   b_digit,
  output logic      [dld_pkg::DIGIT_W-1:0]   diff,
  output logic                               borrow_r
);

  logic [dld_pkg::DIGIT_W:0] a_ext;
  logic [dld_pkg::DIGIT_W:0] b_sum;
  logic [dld_pkg::DIGIT_W:0] tmp;
  logic                      borrow_nxt;

  always_comb begin
    a_ext = {1'b0, a_digit};
    b_sum = {1'b0, b_digit} + {{dld_pkg::DIGIT_W{1'b0}}, borrow_r};
    if (a_ext >= b_sum) begin
      tmp        = a_ext - b_sum;
      borrow_nxt = 1'b0;
    end else begin
      tmp        = a_ext + {1'b0, dld_pkg::RADIX} - b_sum;
      borrow_nxt = 1'b1;
    end
    diff = tmp[dld_pkg::DIGIT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      borrow_r <= 1'b0;
    end else if (ctl.clear) begin
      borrow_r <= 1'b0;
    end else if (ctl.step) begin
      borrow_r <= borrow_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/dld_quot_acc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dld_quot_acc
// Quotient accumulator: shifts in one decimal digit per step (q*10 + d)
// and saturates at the top of the quotient range.
// ----------------------------------------------------------------------------
module dld_quot_acc (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire dld_pkg::acc_ctl_t             ctl,
  input  wire logic [dld_pkg::DIGIT_W-1:0]   digit,
  output logic      [dld_pkg::QUOT_W-1:0]    q_r,
  output logic                               sat_r
);

  localparam int unsigned EW = dld_pkg::QUOT_W + 4;

  logic [EW-1:0]               q_ext;
  logic [EW-1:0]               q_sum;
  logic [dld_pkg::QUOT_W-1:0]  q_nxt;
  logic                        sat_nxt;

  always_comb begin
    q_ext   = {4'b0000, q_r};
    // q*10 as q*8 + q*2
    q_sum   = (q_ext << 3) + (q_ext << 1) + {{(EW-dld_pkg::DIGIT_W){1'b0}}, digit};
    q_nxt   = q_r;
    sat_nxt = sat_r;
    if (!sat_r) begin
      if (q_sum > {4'b0000, dld_pkg::QUOT_MAX}) begin
        q_nxt   = dld_pkg::QUOT_MAX;
        sat_nxt = 1'b1;
      end else begin
        q_nxt   = q_sum[dld_pkg::QUOT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r   <= '0;
      sat_r <= 1'b0;
    end else if (ctl.clear) begin
      q_r   <= '0;
      sat_r <= 1'b0;
    end else if (ctl.step) begin
      q_r   <= q_nxt;
      sat_r <= sat_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/decimal_long_divider_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_long_divider_core
// Decimal long division by repeated digit-serial subtraction.
// ----------------------------------------------------------------------------
// A digit item is taken when idle. An item with last set starts a division:
// each compare or subtract pass walks max(p+1, m) digit offsets through the digit
// RAM read ports before a drain and an evaluation (p = dividend position,
// m = divisor digits); a position with quotient digit d takes 2*d + 1 passes plus
// a step state. Digits may load while a result waits to be taken.
// Reset clears counts, flags and handshake state; the digit RAMs are not cleared.
module decimal_long_divider_core #(
  parameter int unsigned MAX_DIGITS = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_req_type,
  input  wire logic [dld_pkg::DIGIT_W-1:0]   in_digit,
  input  wire logic                          in_last,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [dld_pkg::QUOT_W-1:0]    out_quotient,
  output logic                               out_divide_by_zero,
  output logic                               out_overflow
);

  localparam int unsigned CW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_DIGITS);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_START = 7'b0000010,
    S_PASS  = 7'b0000100,
    S_DRAIN = 7'b0001000,
    S_EVAL  = 7'b0010000,
    S_STEP  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0] n_r, n_nxt;           // dividend digits loaded
  logic [CW-1:0] m_r, m_nxt;           // divisor digits loaded
  logic          len_ovf_r, len_ovf_nxt;
  logic          div_nz_r, div_nz_nxt;
  logic [CW-1:0] p_r, p_nxt;           // dividend position
  logic [CW-1:0] j_r, j_nxt;           // digit offset from the right
  logic [dld_pkg::DIGIT_W-1:0] d_r, d_nxt;
  logic          write_r, write_nxt;   // subtract pass, else compare pass

  logic          st_valid_r, st_valid_nxt;
  logic          st_rem_in_r, st_rem_in_nxt;
  logic          st_div_in_r, st_div_in_nxt;
  logic [AW-1:0] st_addr_r, st_addr_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [dld_pkg::QUOT_W-1:0]    out_q_r, out_q_nxt;
  logic                          out_dz_r, out_dz_nxt;
  logic                          out_ovf_r, out_ovf_nxt;

  logic [dld_pkg::DIGIT_W-1:0] digit_sat;
  logic [CW-1:0]               ra_full;
  logic [CW-1:0]               da_full;
  logic                        rem_in;
  logic                        div_in;
  logic [CW:0]                 j_inc;
  logic [CW:0]                 p_inc;
  logic                        last_issue;
  logic                        digit_done;
  logic [dld_pkg::DIGIT_W-1:0] d_fin;
  logic                        out_free;

  logic                        rem_we;
  logic [AW-1:0]               rem_waddr;
  logic [dld_pkg::DIGIT_W-1:0] rem_wdata;
  logic                        dsr_we;
  logic [dld_pkg::DIGIT_W-1:0] rem_rd;
  logic [dld_pkg::DIGIT_W-1:0] dsr_rd;

  dld_pkg::sub_ctl_t           sub_ctl;
  dld_pkg::acc_ctl_t           acc_ctl;
  logic [dld_pkg::DIGIT_W-1:0] sub_a;
  logic [dld_pkg::DIGIT_W-1:0] sub_b;
  logic [dld_pkg::DIGIT_W-1:0] sub_diff;
  logic                        borrow;
  logic [dld_pkg::QUOT_W-1:0]  acc_q;
  logic                        acc_sat;

  assign digit_sat = (in_digit > dld_pkg::DIGIT_MAX) ? dld_pkg::DIGIT_MAX : in_digit;

  // aligned read addresses for offset j
  assign ra_full    = p_r - j_r;
  assign da_full    = m_r - CW'(1) - j_r;
  assign rem_in     = (j_r <= p_r);
  assign div_in     = (j_r < m_r);
  assign j_inc      = {1'b0, j_r} + (CW+1)'(1);
  assign p_inc      = {1'b0, p_r} + (CW+1)'(1);
  assign last_issue = (j_r >= p_r) && (j_inc >= {1'b0, m_r});

  assign d_fin      = write_r ? (d_r + 4'd1) : d_r;
  assign digit_done = write_r ? (d_r == dld_pkg::DIGIT_MAX) : borrow;
  assign out_free   = !out_valid_r || !out_stall;

  assign sub_a = st_rem_in_r ? rem_rd : '0;
  assign sub_b = st_div_in_r ? dsr_rd : '0;

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_quotient       = out_q_r;
  assign out_divide_by_zero = out_dz_r;
  assign out_overflow       = out_ovf_r;

  assign dsr_we = (state_r == S_IDLE) && in_valid &&
                  (in_req_type == dld_pkg::REQ_DIVISOR) && (m_r < CNT_MAX);

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    m_nxt         = m_r;
    len_ovf_nxt   = len_ovf_r;
    div_nz_nxt    = div_nz_r;
    p_nxt         = p_r;
    j_nxt         = j_r;
    d_nxt         = d_r;
    write_nxt     = write_r;
    st_valid_nxt  = (state_r == S_PASS);
    st_rem_in_nxt = rem_in;
    st_div_in_nxt = div_in;
    st_addr_nxt   = ra_full[AW-1:0];
    out_q_nxt     = out_q_r;
    out_dz_nxt    = out_dz_r;
    out_ovf_nxt   = out_ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    sub_ctl       = '0;
    acc_ctl       = '0;
    rem_we        = 1'b0;
    rem_waddr     = n_r[AW-1:0];
    rem_wdata     = digit_sat;

    sub_ctl.step = st_valid_r;
    // write back the difference during a subtract pass
    if (st_valid_r && write_r && st_rem_in_r) begin
      rem_we    = 1'b1;
      rem_waddr = st_addr_r;
      rem_wdata = sub_diff;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_req_type == dld_pkg::REQ_DIVIDEND) begin
            if (n_r < CNT_MAX) begin
              rem_we = 1'b1;
              n_nxt  = n_r + CW'(1);
            end else begin
              len_ovf_nxt = 1'b1;
            end
          end else begin
            if (m_r < CNT_MAX) begin
              m_nxt = m_r + CW'(1);
              if (digit_sat != '0) begin
                div_nz_nxt = 1'b1;
              end
            end else begin
              len_ovf_nxt = 1'b1;
            end
          end
          if (in_last) begin
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        acc_ctl.clear = 1'b1;
        if (!div_nz_r || (n_r == '0)) begin
          state_nxt = S_DONE;
        end else begin
          p_nxt         = '0;
          j_nxt         = '0;
          d_nxt         = '0;
          write_nxt     = 1'b0;
          sub_ctl.clear = 1'b1;
          state_nxt     = S_PASS;
        end
      end
      S_PASS: begin
        j_nxt = j_inc[CW-1:0];
        if (last_issue) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (digit_done) begin
          acc_ctl.step = 1'b1;
          state_nxt    = S_STEP;
        end else begin
          // compare passed: subtract; subtract done: compare again
          write_nxt     = !write_r;
          d_nxt         = d_fin;
          j_nxt         = '0;
          sub_ctl.clear = 1'b1;
          state_nxt     = S_PASS;
        end
      end
      S_STEP: begin
        if ((p_inc == {1'b0, n_r}) || acc_sat) begin
          state_nxt = S_DONE;
        end else begin
          p_nxt         = p_inc[CW-1:0];
          j_nxt         = '0;
          d_nxt         = '0;
          write_nxt     = 1'b0;
          sub_ctl.clear = 1'b1;
          state_nxt     = S_PASS;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_q_nxt     = acc_q;
          out_dz_nxt    = !div_nz_r;
          out_ovf_nxt   = acc_sat || len_ovf_r;
          n_nxt         = '0;
          m_nxt         = '0;
          len_ovf_nxt   = 1'b0;
          div_nz_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= '0;
      m_r         <= '0;
      len_ovf_r   <= 1'b0;
      div_nz_r    <= 1'b0;
      p_r         <= '0;
      j_r         <= '0;
      d_r         <= '0;
      write_r     <= 1'b0;
      st_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      m_r         <= m_nxt;
      len_ovf_r   <= len_ovf_nxt;
      div_nz_r    <= div_nz_nxt;
      p_r         <= p_nxt;
      j_r         <= j_nxt;
      d_r         <= d_nxt;
      write_r     <= write_nxt;
      st_valid_r  <= st_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_rem_in_r <= st_rem_in_nxt;
    st_div_in_r <= st_div_in_nxt;
    st_addr_r   <= st_addr_nxt;
    out_q_r     <= out_q_nxt;
    out_dz_r    <= out_dz_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  // dividend digits, overwritten in place by the running remainder
  dld_digit_ram #(
    .DEPTH (MAX_DIGITS),
    .AW    (AW)
  ) u_rem_ram (
    .clk     (clk),
    .wr_en   (rem_we),
    .wr_addr (rem_waddr),
    .wr_data (rem_wdata),
    .rd_addr (ra_full[AW-1:0]),
    .rd_data (rem_rd)
  );

  dld_digit_ram #(
    .DEPTH (MAX_DIGITS),
    .AW    (AW)
  ) u_dsr_ram (
    .clk     (clk),
    .wr_en   (dsr_we),
    .wr_addr (m_r[AW-1:0]),
    .wr_data (digit_sat),
    .rd_addr (da_full[AW-1:0]),
    .rd_data (dsr_rd)
  );

  dld_digit_sub u_sub (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (sub_ctl),
    .a_digit  (sub_a),
    .b_digit  (sub_b),
    .diff     (sub_diff),
    .borrow_r (borrow)
  );

  dld_quot_acc u_acc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (acc_ctl),
    .digit (d_fin),
    .q_r   (acc_q),
    .sat_r (acc_sat)
  );

endmodule
`default_nettype wire
